/* hdl/line_rasterizer_macros.svh */
// Assertion macros for the line rasterizer.
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LRAST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LRAST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lrast_pkg.sv */
package lrast_pkg;

    localparam int COORD_BITS = 6;
    // error term holds values from -2*span up to 4*span
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef struct packed {
        t_coord start_col;
        t_coord start_row;
        t_coord end_col;
        t_coord end_row;
    } t_line_in;

    typedef struct packed {
        t_coord pixel_col;
        t_coord pixel_row;
        logic   last_pixel;
    } t_pixel_out;

    typedef enum logic [1:0] {
        ADJ_NONE,
        ADJ_UP,
        ADJ_DOWN
    } t_adj;

    typedef struct packed {
        t_err err;
        t_adj adj;
    } t_err_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } t_state;

endpackage

/* hdl/line_rasterizer.sv */
// Line rasterizer: accepts one segment (start and end point on the grid) and
// emits its pixels from start toward end, one pixel per cycle while the output
// is not stalled, end point last with last_pixel set. The longer span is the
// major axis (row on a tie), and the minor coordinate is the exactly rounded
// (half up) integer position, tracked by one remainder accumulator that adds
// and corrects once per pixel. A segment passes a setup state and then emits
// major-span + 1 pixels; the input stalls from the accepting edge until the
// end point is loaded into the output register.
`include "line_rasterizer_macros.svh"

module line_rasterizer
    import lrast_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_line_in   i_in_data,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_pixel_out o_out_data,
    input  logic       i_out_stall
);

    t_state     r_state, n_state;
    t_line_in   r_line, n_line;
    logic       r_col_major, n_col_major;
    logic       r_neg, n_neg;
    t_coord     r_cnt, n_cnt;
    t_err       r_dmin2, n_dmin2;
    t_err       r_span2, n_span2;
    t_err       r_err, n_err;
    t_coord     r_col, n_col;
    t_coord     r_row, n_row;
    logic       r_out_valid, n_out_valid;
    t_pixel_out r_out_data, n_out_data;

    logic signed [COORD_BITS:0] w_dc, w_dr, w_dmin;
    t_coord                     w_adc, w_adr, w_span;
    logic                       w_col_major;
    logic                       w_emit;
    t_coord                     w_major, w_minor;
    t_err_res                   w_res;

    lrast_err u_err (
        .i_err   (r_err),
        .i_dmin2 (r_dmin2),
        .i_span2 (r_span2),
        .o_res   (w_res)
    );

    // setup arithmetic on the captured segment
    always_comb begin
        w_dc = $signed({1'b0, r_line.end_col}) - $signed({1'b0, r_line.start_col});
        w_dr = $signed({1'b0, r_line.end_row}) - $signed({1'b0, r_line.start_row});
        w_adc = w_dc[COORD_BITS] ? t_coord'(-w_dc) : t_coord'(w_dc);
        w_adr = w_dr[COORD_BITS] ? t_coord'(-w_dr) : t_coord'(w_dr);
        w_col_major = w_adr < w_adc;
        w_span = w_col_major ? w_adc : w_adr;
        w_dmin = w_col_major ? w_dr : w_dc;
    end

    always_comb begin
        w_major = r_col_major ? r_col : r_row;
        w_minor = r_col_major ? r_row : r_col;
        w_major = r_neg ? w_major - 1'b1 : w_major + 1'b1;
        case (w_res.adj)
            ADJ_UP:   w_minor = w_minor + 1'b1;
            ADJ_DOWN: w_minor = w_minor - 1'b1;
            default:  w_minor = w_minor;
        endcase
    end

    assign w_emit = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_line      = r_line;
        n_col_major = r_col_major;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_dmin2     = r_dmin2;
        n_span2     = r_span2;
        n_err       = r_err;
        n_col       = r_col;
        n_row       = r_row;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_line  = i_in_data;
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_col_major = w_col_major;
                n_neg       = w_col_major ? w_dc[COORD_BITS] : w_dr[COORD_BITS];
                n_cnt       = w_span;
                n_dmin2     = {w_dmin[COORD_BITS], w_dmin, 1'b0};
                n_span2     = {2'b00, w_span, 1'b0};
                n_err       = {3'b000, w_span};
                n_col       = r_line.start_col;
                n_row       = r_line.start_row;
                n_state     = ST_RUN;
            end
            ST_RUN: begin
                if (w_emit) begin
                    n_out_valid           = 1'b1;
                    n_out_data.pixel_col  = r_col;
                    n_out_data.pixel_row  = r_row;
                    n_out_data.last_pixel = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        // advance one step along the major axis
                        n_cnt = r_cnt - 1'b1;
                        n_err = w_res.err;
                        if (r_col_major) begin
                            n_col = w_major;
                            n_row = w_minor;
                        end else begin
                            n_row = w_major;
                            n_col = w_minor;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_line      <= n_line;
        r_col_major <= n_col_major;
        r_neg       <= n_neg;
        r_cnt       <= n_cnt;
        r_dmin2     <= n_dmin2;
        r_span2     <= n_span2;
        r_err       <= n_err;
        r_col       <= n_col;
        r_row       <= n_row;
        r_out_data  <= n_out_data;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `LRAST_ASSERT_NEXT(a_accept_setup, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == ST_SETUP, "accepted item did not enter setup")
    `LRAST_ASSERT_NOW(a_err_range, i_clk, i_rst_n, r_state == ST_RUN && r_cnt != '0, r_err >= 0 && r_err < r_span2, "error term out of range")
    `LRAST_ASSERT_NOW(a_end_point, i_clk, i_rst_n, r_state == ST_RUN && r_cnt == '0, r_col == r_line.end_col && r_row == r_line.end_row, "walk did not reach end point")

endmodule

/* hdl/lrast_err.sv */
module lrast_err
    import lrast_pkg::*;
(
    input  t_err     i_err,
    input  t_err     i_dmin2,
    input  t_err     i_span2,
    output t_err_res o_res
);

    t_err w_sum;

    assign w_sum = i_err + i_dmin2;

    // keep the remainder in [0, 2*span): one correction is always enough
    always_comb begin
        if (w_sum >= i_span2) begin
            o_res.err = w_sum - i_span2;
            o_res.adj = ADJ_UP;
        end else if (w_sum < 0) begin
            o_res.err = w_sum + i_span2;
            o_res.adj = ADJ_DOWN;
        end else begin
            o_res.err = w_sum;
            o_res.adj = ADJ_NONE;
        end
    end

endmodule
